@@ rtl/core/tos_pkg.sv @@
// shared types and constants of the tracking overlap statistics block
package tos_pkg;

  // field widths
  localparam int COORD_W   = 16;
  localparam int SIDE_W    = 15;
  localparam int COUNT_W   = 8;
  localparam int AREA_W    = 2 * SIDE_W;
  localparam int UNION_W   = AREA_W + 1;
  localparam int REM_W     = UNION_W + 1;
  localparam int SCORE_W   = 17;
  localparam int TOTAL_W   = 32;
  localparam int SUM_W     = 48;

  // serial divider: one quotient bit per step, integer bit first
  localparam int QUO_STEPS = SCORE_W;
  localparam int STEP_W    = $clog2(QUO_STEPS);

  // stream widths, whole bytes
  localparam int S_TDATA_W = 8 * COORD_W + 3 * COUNT_W;
  localparam int M_TDATA_RAW_W = SCORE_W + 9 * TOTAL_W + SUM_W;
  localparam int M_TDATA_W = ((M_TDATA_RAW_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - M_TDATA_RAW_W;

  localparam int QUEUE_DEPTH_DEF = 2;

  // classified frame handed from front to back
  typedef struct packed {
    logic               clear;
    logic               hit;
    logic               success;
    logic [SIDE_W-1:0]  inter_w;
    logic [SIDE_W-1:0]  inter_h;
    logic [SIDE_W-1:0]  gt_w;
    logic [SIDE_W-1:0]  gt_h;
    logic [SIDE_W-1:0]  res_w;
    logic [SIDE_W-1:0]  res_h;
    logic [COUNT_W-1:0] detect;
    logic [COUNT_W-1:0] coarse;
    logic [COUNT_W-1:0] mlk;
  } tos_job_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } tos_qstat_t;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_G,
    ST_MUL_R,
    ST_UNION,
    ST_DIV,
    ST_UPDATE,
    ST_HOLD
  } tos_state_t;

endpackage

@@ rtl/core/tos_front.sv @@
// front end: takes an input beat and classifies the frame
module tos_front (
  input  logic [tos_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  tos_pkg::tos_qstat_t           qstat,
  output logic                          push,
  output tos_pkg::tos_job_t             job
);

  logic signed [tos_pkg::COORD_W-1:0] gt_x, gt_y, gt_w, gt_h;
  logic signed [tos_pkg::COORD_W-1:0] res_x, res_y, res_w, res_h;
  logic signed [tos_pkg::COORD_W:0]   gt_r, gt_b, res_r, res_b;
  logic signed [tos_pkg::COORD_W-1:0] x1, y1;
  logic signed [tos_pkg::COORD_W:0]   x2, y2;
  logic signed [tos_pkg::COORD_W+1:0] iw, ih;
  logic gw_pos, gh_pos, rw_pos, rh_pos, over_x, over_y, hit;

  // field unpack
  always_comb begin
    gt_x  = s_axis_tdata[15:0];
    gt_y  = s_axis_tdata[31:16];
    gt_w  = s_axis_tdata[47:32];
    gt_h  = s_axis_tdata[63:48];
    res_x = s_axis_tdata[79:64];
    res_y = s_axis_tdata[95:80];
    res_w = s_axis_tdata[111:96];
    res_h = s_axis_tdata[127:112];
  end

  // box edges and intersection sides
  always_comb begin
    gt_r  = {gt_x[15], gt_x} + {gt_w[15], gt_w};
    gt_b  = {gt_y[15], gt_y} + {gt_h[15], gt_h};
    res_r = {res_x[15], res_x} + {res_w[15], res_w};
    res_b = {res_y[15], res_y} + {res_h[15], res_h};
    x1 = (gt_x > res_x) ? gt_x : res_x;
    y1 = (gt_y > res_y) ? gt_y : res_y;
    x2 = (gt_r < res_r) ? gt_r : res_r;
    y2 = (gt_b < res_b) ? gt_b : res_b;
    iw = {x2[16], x2} - {x1[15], x1[15], x1};
    ih = {y2[16], y2} - {y1[15], y1[15], y1};
  end

  // degenerate and disjoint checks
  always_comb begin
    gw_pos = gt_w > 16'sd0;
    gh_pos = gt_h > 16'sd0;
    rw_pos = res_w > 16'sd0;
    rh_pos = res_h > 16'sd0;
    over_x = iw > 18'sd0;
    over_y = ih > 18'sd0;
    hit    = gw_pos && gh_pos && rw_pos && rh_pos && over_x && over_y;
  end

  // job assembly
  always_comb begin
    job.clear   = (gw_pos && gh_pos) || (gt_w[15] && gt_h[15]);
    job.hit     = hit;
    job.success = s_axis_tuser;
    job.inter_w = hit ? iw[tos_pkg::SIDE_W-1:0] : '0;
    job.inter_h = hit ? ih[tos_pkg::SIDE_W-1:0] : '0;
    job.gt_w    = gt_w[tos_pkg::SIDE_W-1:0];
    job.gt_h    = gt_h[tos_pkg::SIDE_W-1:0];
    job.res_w   = res_w[tos_pkg::SIDE_W-1:0];
    job.res_h   = res_h[tos_pkg::SIDE_W-1:0];
    job.detect  = s_axis_tdata[135:128];
    job.coarse  = s_axis_tdata[143:136];
    job.mlk     = s_axis_tdata[151:144];
  end

  // handshake
  assign s_axis_tready = !qstat.full;
  assign push          = s_axis_tvalid && !qstat.full;

endmodule

@@ rtl/core/tos_queue.sv @@
// short register queue between front and back
module tos_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tos_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output tos_pkg::tos_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign qstat.full  = (fill == CNT_W'(DEPTH));
  assign qstat.empty = (fill == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign rdata       = entries[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

@@ rtl/core/tos_back.sv @@
// back end: areas, serial divide, thresholds and running counters
module tos_back (
  input  logic                          clk,
  input  logic                          rst,
  input  tos_pkg::tos_job_t             job_in,
  input  tos_pkg::tos_qstat_t           qstat,
  output logic                          pop,
  output logic [tos_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);

  tos_pkg::tos_state_t state, state_next;
  tos_pkg::tos_job_t   job;

  logic [tos_pkg::SIDE_W-1:0]  mul_a, mul_b;
  logic [tos_pkg::AREA_W-1:0]  product;
  logic [tos_pkg::AREA_W-1:0]  inter, area_g, area_r;
  logic [tos_pkg::UNION_W-1:0] uni;
  logic [tos_pkg::REM_W-1:0]   rem, trial;
  logic [tos_pkg::SCORE_W-1:0] quo, score_val, score;
  logic [tos_pkg::STEP_W-1:0]  step;
  logic                        fits, half_flag, good_flag, is_clear;
  logic [tos_pkg::AREA_W+2:0]  five_i, four_u;

  logic [tos_pkg::TOTAL_W-1:0] frame_total, clear_total, half_hits, good_hits;
  logic [tos_pkg::TOTAL_W-1:0] success_total, fail_total;
  logic [tos_pkg::TOTAL_W-1:0] detect_sum, coarse_sum, mlk_sum;
  logic [tos_pkg::SUM_W-1:0]   score_sum;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tos_pkg::ST_IDLE:   if (!qstat.empty) state_next = tos_pkg::ST_MUL_I;
      tos_pkg::ST_MUL_I:  state_next = tos_pkg::ST_MUL_G;
      tos_pkg::ST_MUL_G:  state_next = tos_pkg::ST_MUL_R;
      tos_pkg::ST_MUL_R:  state_next = tos_pkg::ST_UNION;
      tos_pkg::ST_UNION:  state_next = tos_pkg::ST_DIV;
      tos_pkg::ST_DIV: begin
        if (step == tos_pkg::STEP_W'(tos_pkg::QUO_STEPS - 1)) state_next = tos_pkg::ST_UPDATE;
      end
      tos_pkg::ST_UPDATE: state_next = tos_pkg::ST_HOLD;
      tos_pkg::ST_HOLD:   if (m_axis_tready) state_next = tos_pkg::ST_IDLE;
      default:            state_next = tos_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and shared multiplier operands
  always_comb begin
    pop           = 1'b0;
    m_axis_tvalid = 1'b0;
    mul_a         = job.inter_w;
    mul_b         = job.inter_h;
    case (state)
      tos_pkg::ST_IDLE:  pop = !qstat.empty;
      tos_pkg::ST_MUL_G: begin
        mul_a = job.gt_w;
        mul_b = job.gt_h;
      end
      tos_pkg::ST_MUL_R: begin
        mul_a = job.res_w;
        mul_b = job.res_h;
      end
      tos_pkg::ST_HOLD:  m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign product = mul_a * mul_b;

  // divider step: first step checks the integer bit without a shift
  assign trial = (step == '0) ? rem : {rem[tos_pkg::REM_W-2:0], 1'b0};
  assign fits  = trial >= {1'b0, uni};

  // threshold tests on the exact ratio
  assign five_i    = {3'b0, inter} + {1'b0, inter, 2'b0};
  assign four_u    = {uni, 2'b0};
  assign half_flag = job.hit && ({inter, 1'b0} >= uni);
  assign good_flag = job.hit && (five_i >= four_u);
  assign score_val = job.hit ? quo : '0;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tos_pkg::ST_IDLE;
      frame_total   <= '0;
      clear_total   <= '0;
      half_hits     <= '0;
      good_hits     <= '0;
      success_total <= '0;
      fail_total    <= '0;
      score_sum     <= '0;
      detect_sum    <= '0;
      coarse_sum    <= '0;
      mlk_sum       <= '0;
    end else begin
      state <= state_next;
      if (state == tos_pkg::ST_UPDATE) begin
        frame_total <= frame_total + 1'b1;
        detect_sum  <= detect_sum + {24'b0, job.detect};
        coarse_sum  <= coarse_sum + {24'b0, job.coarse};
        mlk_sum     <= mlk_sum + {24'b0, job.mlk};
        if (job.clear) begin
          clear_total <= clear_total + 1'b1;
          score_sum   <= score_sum + {31'b0, score_val};
          if (half_flag) half_hits <= half_hits + 1'b1;
          if (good_flag) good_hits <= good_hits + 1'b1;
          if (job.success) begin
            success_total <= success_total + 1'b1;
          end else begin
            fail_total <= fail_total + 1'b1;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      tos_pkg::ST_IDLE:  job <= job_in;
      tos_pkg::ST_MUL_I: inter <= product;
      tos_pkg::ST_MUL_G: area_g <= product;
      tos_pkg::ST_MUL_R: area_r <= product;
      tos_pkg::ST_UNION: begin
        uni  <= {1'b0, area_g} + {1'b0, area_r} - {1'b0, inter};
        rem  <= {2'b0, inter};
        quo  <= '0;
        step <= '0;
      end
      tos_pkg::ST_DIV: begin
        rem  <= fits ? trial - {1'b0, uni} : trial;
        quo  <= {quo[tos_pkg::SCORE_W-2:0], fits};
        step <= step + 1'b1;
      end
      tos_pkg::ST_UPDATE: begin
        score    <= score_val;
        is_clear <= job.clear;
      end
      default: ;
    endcase
  end

  // result beat
  assign m_axis_tuser = is_clear;
  assign m_axis_tdata = {{tos_pkg::M_PAD_W{1'b0}}, mlk_sum, coarse_sum, detect_sum,
                         score_sum, fail_total, success_total, good_hits, half_hits,
                         clear_total, frame_total, score};

endmodule

@@ rtl/core/tracking_overlap_statistics.sv @@
// top level: per-frame box overlap score and tracking statistics
//
//   group   dir  tdata fields (low bit first)                   tuser
//   s_axis  in   gt_x gt_y gt_w gt_h res_x res_y res_w res_h     success
//                detect_count coarse_count mlk_count (152 b)
//   m_axis  out  score frame_total clear_total half_hits         is_clear
//                good_hits success_total fail_total score_sum
//                detect_sum coarse_sum mlk_sum, zero pad (360 b)
//
// the back end handles each frame in these steps, in order:
// load, three passes of the shared 15x15 multiplier, union, 17 steps of the
// radix-2 divider, update, result beat
// rst is synchronous and clears the queue, the sequencer and every statistics counter
// the queue keeps taking beats, until it is full, while the back end works or waits on m_axis_tready
module tracking_overlap_statistics #(
  parameter int QUEUE_DEPTH = tos_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // gt_x, gt_y, gt_w, gt_h, res_x, res_y, res_w, res_h, detect, coarse, mlk
  input  logic [tos_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // success
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // score, frame_total, clear_total, half_hits, good_hits, success_total,
  // fail_total, score_sum, detect_sum, coarse_sum, mlk_sum, pad
  output logic [tos_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // is_clear
  output logic                          m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);

  tos_pkg::tos_job_t   job_push, job_pop;
  tos_pkg::tos_qstat_t qstat;
  logic                push, pop;

  // classify incoming frames
  tos_front u_front (
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .qstat         (qstat),
    .push          (push),
    .job           (job_push)
  );

  // decoupling queue
  tos_queue #(
    .WIDTH ($bits(tos_pkg::tos_job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_push),
    .pop   (pop),
    .rdata (job_pop),
    .qstat (qstat)
  );

  // score and statistics
  tos_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_in        (job_pop),
    .qstat         (qstat),
    .pop           (pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

`ifndef ASSERT_OFF
  // the score never exceeds full overlap
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'h10000))
    else $error("score above full overlap");

  // an unclear frame carries a zero score
  a_unclear_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[16:0] == 17'd0))
    else $error("unclear frame with nonzero score");

  // after a result beat the back end returns to idle before the next result
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result repeated after its beat");
`endif

endmodule
